// File: design/tmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared types and codes for the Thumb miscellaneous-group decoder.
// ----------------------------------------------------------------------------
package tmg_pkg;

  localparam int CfgCount   = 5;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] CFG_EXTEND_ROTATE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CP15_V6       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_THUMB2        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REV           = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLX_REG       = 3'd4;

  localparam logic [1:0] ST_UNDEF = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_UNIMP = 2'd2;

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_SPADJ = 3'd1;
  localparam logic [2:0] K_CB    = 3'd2;
  localparam logic [2:0] K_IT    = 3'd3;
  localparam logic [2:0] K_STACK = 3'd4;

  localparam logic [3:0] SP_NUM = 4'd13;

  // Form selectors in bits 11..8
  localparam logic [3:0] GRP_SP_ADJ  = 4'h0;
  localparam logic [3:0] GRP_CB_0    = 4'h1;
  localparam logic [3:0] GRP_EXTEND  = 4'h2;
  localparam logic [3:0] GRP_CB_1    = 4'h3;
  localparam logic [3:0] GRP_PUSH    = 4'h4;
  localparam logic [3:0] GRP_PUSH_LR = 4'h5;
  localparam logic [3:0] GRP_STATE   = 4'h6;
  localparam logic [3:0] GRP_CB_2    = 4'h9;
  localparam logic [3:0] GRP_REV     = 4'hA;
  localparam logic [3:0] GRP_CB_3    = 4'hB;
  localparam logic [3:0] GRP_POP     = 4'hC;
  localparam logic [3:0] GRP_POP_PC  = 4'hD;
  localparam logic [3:0] GRP_BKPT    = 4'hE;
  localparam logic [3:0] GRP_IT      = 4'hF;

  localparam logic [3:0] COND_AL = 4'hE;
  localparam logic [3:0] COND_NV = 4'hF;

  typedef struct packed {
    logic has_extend_rotate;
    logic has_cp15_v6;
    logic has_thumb2;
    logic has_rev;
    logic has_blx_reg;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic        variant;
    logic [3:0]  base_reg;
    logic [8:0]  value;
    logic [15:0] reg_bitmap;
    logic        pc_written;
    logic        undefined_in_it;
    logic        unconditional_in_it;
  } res_t;

endpackage

// File: design/tmg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_cfg_regs
// Feature enable registers, written by index, all set after reset.
// ----------------------------------------------------------------------------
module tmg_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [tmg_pkg::CfgIdxW-1:0]  wr_index,
  input  logic                         wr_data,
  output tmg_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '1;
    end else if (wr_en) begin
      case (wr_index)
        tmg_pkg::CFG_EXTEND_ROTATE: cfg.has_extend_rotate <= wr_data;
        tmg_pkg::CFG_CP15_V6:       cfg.has_cp15_v6       <= wr_data;
        tmg_pkg::CFG_THUMB2:        cfg.has_thumb2        <= wr_data;
        tmg_pkg::CFG_REV:           cfg.has_rev           <= wr_data;
        tmg_pkg::CFG_BLX_REG:       cfg.has_blx_reg       <= wr_data;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

endmodule

// File: design/tmg_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_decode
// Combinational decode of one miscellaneous-group halfword (bits 11..0).
// ----------------------------------------------------------------------------
module tmg_decode (
  input  logic [15:0]    op,
  input  tmg_pkg::cfg_t  cfg,
  output tmg_pkg::res_t  res
);

  logic       pop;
  logic       rb;
  logic       setend;
  logic       cps;
  logic [3:0] fc;
  logic [3:0] mask;
  logic       mask_one_hot;

  assign pop          = op[11];
  assign rb           = op[8];
  assign setend       = (op[7:4] == 4'b0101);
  assign cps          = (op[7:5] == 3'b011) && !op[3];
  assign fc           = op[7:4];
  assign mask         = op[3:0];
  assign mask_one_hot = (mask != 4'd0) && ((mask & (mask - 4'd1)) == 4'd0);

  always_comb begin
    res = '0;
    case (op[11:8]) inside
      tmg_pkg::GRP_SP_ADJ: begin
        res.status   = tmg_pkg::ST_OK;
        res.kind     = tmg_pkg::K_SPADJ;
        res.variant  = op[7];
        res.base_reg = tmg_pkg::SP_NUM;
        res.value    = {op[6:0], 2'b00};
      end
      tmg_pkg::GRP_EXTEND: begin
        if (cfg.has_extend_rotate) res.status = tmg_pkg::ST_UNIMP;
      end
      tmg_pkg::GRP_PUSH, tmg_pkg::GRP_PUSH_LR, tmg_pkg::GRP_POP,
      tmg_pkg::GRP_POP_PC: begin
        // empty list is undefined
        if (op[8:0] != 9'd0) begin
          res.status     = tmg_pkg::ST_OK;
          res.kind       = tmg_pkg::K_STACK;
          res.variant    = pop;
          res.base_reg   = tmg_pkg::SP_NUM;
          res.reg_bitmap = {pop & rb, ~pop & rb, 6'd0, op[7:0]};
          res.pc_written = pop & rb;
        end
      end
      tmg_pkg::GRP_STATE: begin
        if ((setend || cps) && cfg.has_cp15_v6) res.status = tmg_pkg::ST_UNIMP;
      end
      tmg_pkg::GRP_CB_0, tmg_pkg::GRP_CB_1, tmg_pkg::GRP_CB_2,
      tmg_pkg::GRP_CB_3: begin
        if (cfg.has_thumb2) begin
          res.status          = tmg_pkg::ST_OK;
          res.kind            = tmg_pkg::K_CB;
          res.variant         = op[11];
          res.base_reg        = {1'b0, op[2:0]};
          res.value           = {2'b00, op[9], op[7:3], 1'b0};
          res.pc_written      = 1'b1;
          res.undefined_in_it = 1'b1;
        end
      end
      tmg_pkg::GRP_IT: begin
        if (cfg.has_thumb2) begin
          if (mask == 4'd0) begin
            res.status = tmg_pkg::ST_UNIMP;  // hint space
          end else if (!(fc == tmg_pkg::COND_NV ||
                         (fc == tmg_pkg::COND_AL && !mask_one_hot))) begin
            res.status = tmg_pkg::ST_OK;
            res.kind   = tmg_pkg::K_IT;
            res.value  = {1'b0, fc, mask};
          end
        end
      end
      tmg_pkg::GRP_REV: begin
        if (cfg.has_rev) res.status = tmg_pkg::ST_UNIMP;
      end
      tmg_pkg::GRP_BKPT: begin
        if (cfg.has_blx_reg) begin
          res.status              = tmg_pkg::ST_UNIMP;
          res.unconditional_in_it = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/thumb_misc_group_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb_misc_group_decoder_core
// Decoder for the 16-bit Thumb miscellaneous instruction group.
// ----------------------------------------------------------------------------
// One instruction is taken per clock while start is high; busy is always low.
// Each instruction gives exactly one result, with done high for one cycle
// after the instruction passes the input register and then the result
// register, in order; the receiver cannot stall and must take every result
// as it appears.
// Feature registers are written through wr_en/wr_index/wr_data and all read
// as enabled after reset; write them only while no instruction is in flight.
module thumb_misc_group_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [15:0]                  instruction,
  input  logic                         wr_en,
  input  logic [tmg_pkg::CfgIdxW-1:0]  wr_index,
  input  logic                         wr_data,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [2:0]                   kind,
  output logic                         variant,
  output logic [3:0]                   base_reg,
  output logic [8:0]                   value,
  output logic [15:0]                  reg_bitmap,
  output logic                         pc_written,
  output logic                         undefined_in_it,
  output logic                         unconditional_in_it
);

  tmg_pkg::cfg_t cfg;
  tmg_pkg::res_t res_next;
  tmg_pkg::res_t res;
  logic [15:0]   op;
  logic          op_valid;

  assign busy = 1'b0;

  tmg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op <= instruction;
    end
  end

  tmg_decode u_decode (
    .op  (op),
    .cfg (cfg),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      res <= res_next;
    end
  end

  assign status              = res.status;
  assign kind                = res.kind;
  assign variant             = res.variant;
  assign base_reg            = res.base_reg;
  assign value               = res.value;
  assign reg_bitmap          = res.reg_bitmap;
  assign pc_written          = res.pc_written;
  assign undefined_in_it     = res.undefined_in_it;
  assign unconditional_in_it = res.unconditional_in_it;

endmodule
